FILE: src/uvcfa_pkg.sv
// shared types and constants for the mjpeg frame assembler
`default_nettype none

package uvcfa_pkg;

    localparam int unsigned LEN_W = 23;
    localparam int unsigned POS_W = 22;

    localparam logic [LEN_W:0]   MAX_FRAME_BYTES  = 24'd8388608;
    localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = 23'd4194304;

    localparam logic [7:0] FLAG_FID_BIT = 8'h01;
    localparam logic [7:0] FLAG_EOF_BIT = 8'h02;
    localparam logic [7:0] FLAG_PTS_BIT = 8'h04;
    localparam logic [7:0] FLAG_ERR_BIT = 8'h40;

    localparam logic [7:0] JPEG_FF  = 8'hff;
    localparam logic [7:0] JPEG_SOI = 8'hd8;
    localparam logic [7:0] JPEG_EOI = 8'hd9;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // what one input byte asks the back end to emit
    typedef struct packed {
        logic             wr_valid;
        logic [LEN_W-1:0] wr_offset;
        logic [7:0]       wr_data;
        logic             rep_valid;
        logic [LEN_W-1:0] rep_length;
        logic             rep_good;
    } request_t;

endpackage

`default_nettype wire

FILE: src/uvcfa_front.sv
// front end: header parsing, frame tracking and request generation per byte
`default_nettype none

module uvcfa_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            packet_first,
    input  wire logic [uvcfa_pkg::LEN_W-1:0]     packet_length,
    output      logic                            push,
    output      uvcfa_pkg::request_t             req
);

    localparam logic [1:0] SOM_NONE = 2'd0;
    localparam logic [1:0] SOM_FF   = 2'd1;
    localparam logic [1:0] SOM_OK   = 2'd2;
    localparam logic [1:0] SOM_BAD  = 2'd3;

    logic [uvcfa_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [uvcfa_pkg::LEN_W-1:0] packet_size_reg, packet_size_next;
    logic [uvcfa_pkg::LEN_W-1:0] payload_reg, payload_next;
    logic [7:0]                  header_size_reg, header_size_next;
    logic [7:0]                  flags_reg, flags_next;
    logic                        ignored_reg, ignored_next;
    logic                        appends_reg, appends_next;
    logic [31:0]                 ts_shift_reg, ts_shift_next;
    logic                        fid_reg, fid_next;
    logic                        fid_known_reg, fid_known_next;
    logic [31:0]                 last_ts_reg, last_ts_next;
    logic                        ts_known_reg, ts_known_next;
    logic                        error_reg, error_next;
    logic [uvcfa_pkg::LEN_W-1:0] frame_size_reg, frame_size_next;
    logic [uvcfa_pkg::LEN_W-1:0] eoi_end_reg, eoi_end_next;
    logic                        prev_ff_reg, prev_ff_next;
    logic [1:0]                  som_reg, som_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            packet_size_reg <= '0;
            payload_reg     <= '0;
            header_size_reg <= '0;
            flags_reg       <= '0;
            ignored_reg     <= 1'b0;
            appends_reg     <= 1'b0;
            ts_shift_reg    <= '0;
            fid_reg         <= 1'b0;
            fid_known_reg   <= 1'b0;
            last_ts_reg     <= '0;
            ts_known_reg    <= 1'b0;
            error_reg       <= 1'b0;
            frame_size_reg  <= '0;
            eoi_end_reg     <= '0;
            prev_ff_reg     <= 1'b0;
            som_reg         <= SOM_NONE;
        end
        else
        begin
            pos_reg         <= pos_next;
            packet_size_reg <= packet_size_next;
            payload_reg     <= payload_next;
            header_size_reg <= header_size_next;
            flags_reg       <= flags_next;
            ignored_reg     <= ignored_next;
            appends_reg     <= appends_next;
            ts_shift_reg    <= ts_shift_next;
            fid_reg         <= fid_next;
            fid_known_reg   <= fid_known_next;
            last_ts_reg     <= last_ts_next;
            ts_known_reg    <= ts_known_next;
            error_reg       <= error_next;
            frame_size_reg  <= frame_size_next;
            eoi_end_reg     <= eoi_end_next;
            prev_ff_reg     <= prev_ff_next;
            som_reg         <= som_next;
        end
    end

    always_comb
    begin
        logic [uvcfa_pkg::LEN_W-1:0] idx;
        logic [uvcfa_pkg::LEN_W-1:0] idx_p1;
        logic [uvcfa_pkg::LEN_W-1:0] hs;
        logic [7:0]                  flags;
        logic [31:0]                 ts;
        logic [uvcfa_pkg::LEN_W-1:0] fs;
        logic [uvcfa_pkg::LEN_W-1:0] eoi;
        logic                        pff;
        logic [1:0]                  som;
        logic                        err;
        logic                        has_pts;
        logic [uvcfa_pkg::LEN_W:0]   fill;

        pos_next         = pos_reg;
        packet_size_next = packet_size_reg;
        payload_next     = payload_reg;
        header_size_next = header_size_reg;
        flags_next       = flags_reg;
        ignored_next     = ignored_reg;
        appends_next     = appends_reg;
        ts_shift_next    = ts_shift_reg;
        fid_next         = fid_reg;
        fid_known_next   = fid_known_reg;
        last_ts_next     = last_ts_reg;
        ts_known_next    = ts_known_reg;
        error_next       = error_reg;
        frame_size_next  = frame_size_reg;
        eoi_end_next     = eoi_end_reg;
        prev_ff_next     = prev_ff_reg;
        som_next         = som_reg;
        req              = '0;

        idx     = {1'b0, pos_reg} + 23'd1;
        idx_p1  = idx + 23'd1;
        hs      = {15'd0, header_size_reg};
        flags   = flags_reg;
        ts      = ts_shift_reg;
        fs      = frame_size_reg;
        eoi     = eoi_end_reg;
        pff     = prev_ff_reg;
        som     = som_reg;
        err     = error_reg;
        has_pts = 1'b0;
        fill    = '0;

        if (in_valid)
        begin
            if (packet_first)
            begin
                packet_size_next = packet_length;
                payload_next     = packet_length - {15'd0, data_byte};
                pos_next         = '0;
                header_size_next = data_byte;
                flags_next       = '0;
                ts_shift_next    = '0;
                appends_next     = 1'b0;
                ignored_next     = (packet_length < 23'd2)
                                || (packet_length > uvcfa_pkg::MAX_PACKET_BYTES)
                                || (data_byte < 8'd2)
                                || ({15'd0, data_byte} > packet_length);
            end
            else if (!ignored_reg)
            begin
                if (idx >= packet_size_reg)
                begin
                    // byte beyond the announced packet length
                    ignored_next = 1'b1;
                end
                else
                begin
                    pos_next = idx[uvcfa_pkg::POS_W-1:0];
                    if (idx == 23'd1)
                    begin
                        flags      = data_byte;
                        flags_next = data_byte;
                    end
                    if (idx == 23'd1 && (data_byte & uvcfa_pkg::FLAG_ERR_BIT) != 8'd0)
                    begin
                        frame_size_next = '0;
                        eoi_end_next    = '0;
                        prev_ff_next    = 1'b0;
                        som_next        = SOM_NONE;
                        error_next      = 1'b1;
                        ignored_next    = 1'b1;
                    end
                    else
                    begin
                        if (idx >= 23'd2 && idx <= 23'd5 && idx < hs)
                        begin
                            case (idx[1:0])
                                2'd2:    ts[7:0]   = data_byte;
                                2'd3:    ts[15:8]  = data_byte;
                                2'd0:    ts[23:16] = data_byte;
                                default: ts[31:24] = data_byte;
                            endcase
                        end
                        ts_shift_next = ts;

                        // last header byte: frame-id / timestamp checks, append decision
                        if (idx_p1 == hs)
                        begin
                            has_pts = ((flags & uvcfa_pkg::FLAG_PTS_BIT) != 8'd0)
                                   && (header_size_reg >= 8'd6);
                            if ((fid_known_reg && flags[0] != fid_reg)
                                || (has_pts && ts_known_reg && ts != last_ts_reg))
                            begin
                                fs  = '0;
                                eoi = '0;
                                pff = 1'b0;
                                som = SOM_NONE;
                                err = 1'b0;
                            end
                            fid_next       = flags[0];
                            fid_known_next = 1'b1;
                            if (has_pts)
                            begin
                                last_ts_next  = ts;
                                ts_known_next = 1'b1;
                            end
                            fill         = {1'b0, fs} + {1'b0, payload_reg};
                            appends_next = (payload_reg != '0)
                                        && (fill < uvcfa_pkg::MAX_FRAME_BYTES);
                        end

                        if (idx >= hs && appends_reg)
                        begin
                            req.wr_valid  = 1'b1;
                            req.wr_offset = fs;
                            req.wr_data   = data_byte;
                            if (fs == '0)
                                som = (data_byte == uvcfa_pkg::JPEG_FF) ? SOM_FF : SOM_BAD;
                            else if (fs == 23'd1 && som == SOM_FF)
                                som = (data_byte == uvcfa_pkg::JPEG_SOI) ? SOM_OK : SOM_BAD;
                            fs = fs + 23'd1;
                            if (pff && data_byte == uvcfa_pkg::JPEG_EOI)
                                eoi = fs;
                            pff = (data_byte == uvcfa_pkg::JPEG_FF);
                        end

                        if (idx_p1 == packet_size_reg)
                        begin
                            ignored_next = 1'b1;
                            if ((flags & uvcfa_pkg::FLAG_EOF_BIT) != 8'd0)
                            begin
                                req.rep_valid  = 1'b1;
                                req.rep_length = eoi;
                                req.rep_good   = !err && (eoi > 23'd4) && (som == SOM_OK);
                                fs  = '0;
                                eoi = '0;
                                pff = 1'b0;
                                som = SOM_NONE;
                                err = 1'b0;
                            end
                        end

                        frame_size_next = fs;
                        eoi_end_next    = eoi;
                        prev_ff_next    = pff;
                        som_next        = som;
                        error_next      = err;
                    end
                end
            end
        end
        push = req.wr_valid | req.rep_valid;
    end

endmodule

`default_nettype wire

FILE: src/uvcfa_fifo.sv
// short request queue between front and back end
`default_nettype none

module uvcfa_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire uvcfa_pkg::request_t push_req,
    input  wire logic                pop,
    output      logic                full,
    output      logic                head_valid,
    output      uvcfa_pkg::request_t head_req
);

    uvcfa_pkg::request_t mem [uvcfa_pkg::QUEUE_DEPTH];

    logic [uvcfa_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [uvcfa_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [uvcfa_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full       = (count_reg == (uvcfa_pkg::QUEUE_AW+1)'(uvcfa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + (uvcfa_pkg::QUEUE_AW)'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + (uvcfa_pkg::QUEUE_AW)'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (uvcfa_pkg::QUEUE_AW+1)'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - (uvcfa_pkg::QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/uvcfa_back.sv
// back end: splits each request into results and drives the output register
`default_nettype none

module uvcfa_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire uvcfa_pkg::request_t head_req,
    output      logic                pop,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic                out_kind,
    output      logic [55:0]         out_data,
    output      logic                out_last
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [55:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic        load;
    logic        emit_write;

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

    assign load = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        emit_write = head_req.wr_valid && !phase_reg;

        if (valid_reg && out_ready)
            valid_next = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            if (emit_write)
            begin
                kind_next = 1'b0;
                data_next = {1'b0, 1'b0, 23'd0, head_req.wr_data, head_req.wr_offset};
            end
            else
            begin
                kind_next = 1'b1;
                data_next = {1'b0, head_req.rep_good, head_req.rep_length, 8'd0, 23'd0};
            end
            // a write followed by a report takes two slots
            if (emit_write && head_req.rep_valid)
            begin
                last_next  = 1'b0;
                phase_next = 1'b1;
            end
            else
            begin
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

FILE: src/uvc_mjpeg_frame_assembler_core.sv
// top level of the mjpeg frame assembler: front end, request queue, back end
// each result passes from the front end through the request queue into the output register that drives m_*
// throughput: one byte per cycle; an end-of-frame byte with a payload write takes two output slots
// input stalls only when the four-entry request queue between front and back end is full
// reset: asynchronous active-low rst_n clears all packet and frame state and empties the queue
`default_nettype none

module uvc_mjpeg_frame_assembler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // data_byte[7:0], packet_length[30:8], zero pad
    input  wire logic        s_tuser,   // packet_first
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // write_offset[22:0], write_data[30:23],
                                        // frame_length[53:31], frame_good[54], zero pad
    output      logic        m_tuser,   // result_kind
    output      logic        m_tlast
);

    uvcfa_pkg::request_t front_req;
    uvcfa_pkg::request_t head_req;
    logic                front_push;
    logic                queue_full;
    logic                head_valid;
    logic                back_pop;
    logic                accept;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    uvcfa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .data_byte     (s_tdata[7:0]),
        .packet_first  (s_tuser),
        .packet_length (s_tdata[30:8]),
        .push          (front_push),
        .req           (front_req)
    );

    uvcfa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_req   (front_req),
        .pop        (back_pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    uvcfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (back_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/tb_uvc_mjpeg_frame_assembler_checker.sv
// checker for the mjpeg frame assembler: predicts buffer writes and frame reports, compares them
module tb_uvc_mjpeg_frame_assembler_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,    // data_byte[7:0], packet_length[30:8], zero pad
    input  wire logic        s_tuser,    // packet_first
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,    // write_offset[22:0], write_data[30:23],
                                         // frame_length[53:31], frame_good[54], zero pad
    input  wire logic        m_tuser,    // result_kind
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               ops_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic RESULT_WRITE  = 1'b0;
    localparam logic RESULT_REPORT = 1'b1;

    typedef enum logic [1:0] {SOI_NONE, SOI_FF_SEEN, SOI_OK, SOI_BAD} soi_state_t;

    typedef struct packed {
        logic                        kind;
        logic [uvcfa_pkg::LEN_W-1:0] offset;
        logic [7:0]                  data;
        logic [uvcfa_pkg::LEN_W-1:0] length;
        logic                        good;
        logic                        last;
    } buffer_op_t;

    buffer_op_t predicted_ops[$];

    // packet state
    logic [uvcfa_pkg::POS_W-1:0] pkt_pos;
    logic [uvcfa_pkg::LEN_W-1:0] pkt_size;
    logic [7:0]                  hdr_len;
    logic [7:0]                  hdr_flags;
    logic                        skip_packet;
    logic                        take_payload;
    logic [31:0]                 pts_accum;
    // stream state
    logic                        cur_fid;
    logic                        fid_valid;
    logic [31:0]                 prev_pts;
    logic                        pts_valid;
    // frame state
    logic                        frame_bad;
    logic [uvcfa_pkg::LEN_W-1:0] fill;
    logic [uvcfa_pkg::LEN_W-1:0] eoi_len;
    logic                        last_ff;
    soi_state_t                  soi;

    function automatic void drop_frame();
        fill    = '0;
        eoi_len = '0;
        last_ff = 1'b0;
        soi     = SOI_NONE;
    endfunction

    function automatic void reset_model();
        pkt_pos      = '0;
        pkt_size     = '0;
        hdr_len      = '0;
        hdr_flags    = '0;
        skip_packet  = 1'b0;
        take_payload = 1'b0;
        pts_accum    = '0;
        cur_fid      = 1'b0;
        fid_valid    = 1'b0;
        prev_pts     = '0;
        pts_valid    = 1'b0;
        frame_bad    = 1'b0;
        drop_frame();
    endfunction

    // header complete: frame-id / timestamp change and whole-payload append decision
    function automatic void close_header();
        logic                        fid;
        logic                        has_pts;
        logic [uvcfa_pkg::LEN_W-1:0] payload;
        fid     = (hdr_flags & uvcfa_pkg::FLAG_FID_BIT) != 0;
        has_pts = (hdr_flags & uvcfa_pkg::FLAG_PTS_BIT) != 0 && hdr_len >= 6;
        if ((fid_valid && fid != cur_fid) || (has_pts && pts_valid && pts_accum != prev_pts))
        begin
            drop_frame();
            frame_bad = 1'b0;
        end
        cur_fid   = fid;
        fid_valid = 1'b1;
        if (has_pts)
        begin
            prev_pts  = pts_accum;
            pts_valid = 1'b1;
        end
        payload      = pkt_size - {15'b0, hdr_len};
        take_payload = payload != 0
                    && ({1'b0, fill} + {1'b0, payload}) < uvcfa_pkg::MAX_FRAME_BYTES;
    endfunction

    task automatic assemble_byte(input logic [7:0] b, input logic first,
                                 input logic [uvcfa_pkg::LEN_W-1:0] len);
        logic [uvcfa_pkg::LEN_W-1:0] idx;
        buffer_op_t                  wr;
        buffer_op_t                  rep;
        logic                        wr_hit;
        logic                        rep_hit;
        wr      = '0;
        rep     = '0;
        wr_hit  = 1'b0;
        rep_hit = 1'b0;
        if (first)
        begin
            pkt_size     = len;
            pkt_pos      = '0;
            hdr_len      = b;
            hdr_flags    = '0;
            pts_accum    = '0;
            take_payload = 1'b0;
            skip_packet  = len < 2 || len > uvcfa_pkg::MAX_PACKET_BYTES || b < 2
                        || {15'b0, b} > len;
            return;
        end
        if (skip_packet)
            return;
        idx = {1'b0, pkt_pos} + 1'b1;
        if (idx >= pkt_size)
        begin
            skip_packet = 1'b1;
            return;
        end
        pkt_pos = idx[uvcfa_pkg::POS_W-1:0];

        if (idx == 1)
        begin
            hdr_flags = b;
            if ((b & uvcfa_pkg::FLAG_ERR_BIT) != 0)
            begin
                drop_frame();
                frame_bad   = 1'b1;
                skip_packet = 1'b1;
                return;
            end
        end
        if (idx >= 2 && idx <= 5 && idx < {15'b0, hdr_len})
            pts_accum |= {24'b0, b} << (8 * (idx - 2));
        if (idx + 1 == {15'b0, hdr_len})
            close_header();

        if (idx >= {15'b0, hdr_len} && take_payload)
        begin
            wr_hit    = 1'b1;
            wr.kind   = RESULT_WRITE;
            wr.offset = fill;
            wr.data   = b;
            if (fill == 0)
                soi = (b == uvcfa_pkg::JPEG_FF) ? SOI_FF_SEEN : SOI_BAD;
            else if (fill == 1 && soi == SOI_FF_SEEN)
                soi = (b == uvcfa_pkg::JPEG_SOI) ? SOI_OK : SOI_BAD;
            fill = fill + 1'b1;
            if (last_ff && b == uvcfa_pkg::JPEG_EOI)
                eoi_len = fill;
            last_ff = b == uvcfa_pkg::JPEG_FF;
        end

        if (idx + 1 == pkt_size)
        begin
            skip_packet = 1'b1;
            if ((hdr_flags & uvcfa_pkg::FLAG_EOF_BIT) != 0)
            begin
                rep_hit    = 1'b1;
                rep.kind   = RESULT_REPORT;
                rep.length = eoi_len;
                rep.good   = !frame_bad && eoi_len > 4 && soi == SOI_OK;
                drop_frame();
                frame_bad = 1'b0;
            end
        end

        if (wr_hit)
        begin
            wr.last       = !rep_hit;
            predicted_ops = {predicted_ops, wr};
        end
        if (rep_hit)
        begin
            rep.last      = 1'b1;
            predicted_ops = {predicted_ops, rep};
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count  = 0;
        ops_waiting = 0;
        reset_model();
    end

    always @(posedge clk)
    begin : watch
        buffer_op_t want;
        if (!rst_n)
        begin
            reset_model();
            predicted_ops.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                assemble_byte(s_tdata[7:0], s_tuser, s_tdata[30:8]);
            if (m_tvalid && m_tready)
            begin
                if (predicted_ops.size() == 0)
                begin
                    $error("result with nothing predicted: result_kind %0d, m_tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_ops[0];
                    predicted_ops.delete(0);
                    check_field("result_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("write_offset", 32'(want.offset), 32'(m_tdata[22:0]));
                    check_field("write_data", 32'(want.data), 32'(m_tdata[30:23]));
                    check_field("frame_length", 32'(want.length), 32'(m_tdata[53:31]));
                    check_field("frame_good", 32'(want.good), 32'(m_tdata[54]));
                    check_field("last_result", 32'(want.last), 32'(m_tlast));
                end
            end
        end
        ops_waiting <= predicted_ops.size();
    end

endmodule

FILE: tb/tb_uvc_mjpeg_frame_assembler_core.sv
// testbench top for the mjpeg frame assembler: packet and frame stimulus, flow control, verdict
module tb_uvc_mjpeg_frame_assembler_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int ops_waiting;
    int cycle_count = 0;
    int idle_pct;
    int stall_pct;
    int sent_items;
    logic frame_fid;

    logic [7:0] pkt_q[$];
    logic [7:0] jpeg_q[$];

    uvc_mjpeg_frame_assembler_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tb_uvc_mjpeg_frame_assembler_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .ops_waiting (ops_waiting)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= $urandom_range(99) >= stall_pct;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void add_pkt_byte(input logic [7:0] b);
        pkt_q = {pkt_q, b};
    endfunction

    function automatic void add_jpeg_byte(input logic [7:0] b);
        jpeg_q = {jpeg_q, b};
    endfunction

    function automatic logic [7:0] take_jpeg_byte();
        logic [7:0] b;
        b = jpeg_q[0];
        jpeg_q.delete(0);
        return b;
    endfunction

    // one request per byte; valid stays up across back-to-back requests
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [22:0] len);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len, b};
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic ship_packet(input logic [22:0] len, input int count);
        for (int i = 0; i < count; i++)
            send_byte(pkt_q[i], i == 0, (i == 0) ? len : 23'($urandom));
    endtask

    function automatic void make_header(input int hlen, input logic [7:0] flags,
                                        input logic [31:0] pts);
        pkt_q.delete();
        add_pkt_byte(8'(hlen));
        add_pkt_byte(flags);
        for (int i = 2; i < hlen; i++)
            add_pkt_byte((i <= 5) ? pts[8*(i-2) +: 8] : 8'($urandom));
    endfunction

    // biased toward marker bytes so FF D8 / FF D9 pairs show up often
    function automatic logic [7:0] jpeg_byte();
        case ($urandom_range(7))
            0: return uvcfa_pkg::JPEG_FF;
            1: return uvcfa_pkg::JPEG_EOI;
            2: return uvcfa_pkg::JPEG_SOI;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_noise();
        int sel;
        int len;
        int hlen;
        sel = $urandom_range(7);
        case (sel)
            0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 23'($urandom));
            1:
            begin
                send_byte(8'($urandom), 1'b1, 23'd1);
                send_byte(8'($urandom), 1'b0, 23'($urandom));
            end
            2:
            begin
                send_byte(8'($urandom_range(2, 6)), 1'b1, 23'($urandom_range(4194305, 8388607)));
                repeat (2) send_byte(8'($urandom), 1'b0, 23'($urandom));
            end
            3:
            begin
                // header length below two or past the packet
                len  = $urandom_range(2, 10);
                hlen = $urandom_range(1) ? $urandom_range(1) : $urandom_range(len + 1, 255);
                make_header(hlen, 8'($urandom), $urandom);
                ship_packet(23'(len), $urandom_range(1, pkt_q.size()));
            end
            4:
            begin
                make_header($urandom_range(2, 6), 8'($urandom) | uvcfa_pkg::FLAG_ERR_BIT,
                            $urandom);
                repeat ($urandom_range(4)) add_pkt_byte(jpeg_byte());
                ship_packet(23'(pkt_q.size()), pkt_q.size());
            end
            5:
            begin
                // announced longer than sent, the next packet cuts it off
                make_header($urandom_range(2, 8), 8'($urandom) & ~uvcfa_pkg::FLAG_ERR_BIT,
                            $urandom);
                repeat ($urandom_range(1, 6)) add_pkt_byte(jpeg_byte());
                ship_packet(23'(pkt_q.size() + $urandom_range(1, 5)), pkt_q.size());
            end
            default:
            begin
                make_header($urandom_range(2, 8), 8'($urandom) & ~uvcfa_pkg::FLAG_ERR_BIT,
                            $urandom);
                repeat ($urandom_range(6)) add_pkt_byte(jpeg_byte());
                ship_packet(23'(pkt_q.size()), pkt_q.size());
                if (sel == 7)
                    repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0, 23'($urandom));
            end
        endcase
    endtask

    task automatic send_frame();
        int shape;
        int chunk;
        int hlen;
        logic [7:0] flags;
        logic [31:0] pts;
        logic eof;
        jpeg_q.delete();
        shape = $urandom_range(9);
        if (shape <= 8)
        begin
            add_jpeg_byte(uvcfa_pkg::JPEG_FF);
            add_jpeg_byte((shape == 8) ? 8'($urandom) : uvcfa_pkg::JPEG_SOI);
            repeat ($urandom_range(30)) add_jpeg_byte(jpeg_byte());
            if (shape != 6)
            begin
                add_jpeg_byte(uvcfa_pkg::JPEG_FF);
                add_jpeg_byte(uvcfa_pkg::JPEG_EOI);
            end
            repeat ($urandom_range(3)) add_jpeg_byte(jpeg_byte());
        end
        else
        begin
            // no start marker at all
            repeat ($urandom_range(20)) add_jpeg_byte(jpeg_byte());
        end
        if (shape == 5)
        begin
            // FF D8 FF D9 alone is too short to deliver
            jpeg_q.delete();
            add_jpeg_byte(uvcfa_pkg::JPEG_FF);
            add_jpeg_byte(uvcfa_pkg::JPEG_SOI);
            add_jpeg_byte(uvcfa_pkg::JPEG_FF);
            add_jpeg_byte(uvcfa_pkg::JPEG_EOI);
        end

        frame_fid = ~frame_fid;
        pts       = $urandom;
        do
        begin
            chunk = $urandom_range(12);
            if (chunk > jpeg_q.size())
                chunk = jpeg_q.size();
            eof = chunk == jpeg_q.size() && $urandom_range(5) != 0;
            case ($urandom_range(3))
                0: hlen = 2;
                1: hlen = 6;
                2: hlen = 12;
                default: hlen = $urandom_range(2, 8);
            endcase
            flags = (8'($urandom) & 8'hb8) | (frame_fid ? uvcfa_pkg::FLAG_FID_BIT : 8'h00) |
                    ($urandom_range(1) ? uvcfa_pkg::FLAG_PTS_BIT : 8'h00) |
                    (eof ? uvcfa_pkg::FLAG_EOF_BIT : 8'h00);
            make_header(hlen, flags, pts);
            repeat (chunk) add_pkt_byte(take_jpeg_byte());
            ship_packet(23'(pkt_q.size()), pkt_q.size());
            sent_items += pkt_q.size();
            if ($urandom_range(99) < 12)
                send_noise();
        end while (!eof);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        sent_items = 0;
        frame_fid  = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte before any packet
        send_byte(8'h00, 1'b0, '0);
        // too short to hold a header
        send_byte(8'hff, 1'b1, 23'd1);
        // length above the packet limit, its next byte is dropped
        send_byte(8'h02, 1'b1, 23'h7fffff);
        send_byte(8'hff, 1'b0, 23'h7fffff);
        // header length below two, then above the packet length
        send_byte(8'h01, 1'b1, 23'd4);
        send_byte(8'h00, 1'b0, '0);
        send_byte(8'hff, 1'b1, 23'd3);
        // largest legal packet, abandoned by the next packet
        send_byte(8'h02, 1'b1, uvcfa_pkg::MAX_PACKET_BYTES);
        send_byte(8'h00, 1'b0, '0);
        // error flag clears the frame
        send_byte(8'h02, 1'b1, 23'd3);
        send_byte(uvcfa_pkg::FLAG_ERR_BIT, 1'b0, '0);
        send_byte(8'h12, 1'b0, '0);
        // smallest deliverable frame with a timestamp, then a byte past the end
        make_header(6, uvcfa_pkg::FLAG_EOF_BIT | uvcfa_pkg::FLAG_PTS_BIT |
                    uvcfa_pkg::FLAG_FID_BIT, 32'hffff_ffff);
        add_pkt_byte(uvcfa_pkg::JPEG_FF);
        add_pkt_byte(uvcfa_pkg::JPEG_SOI);
        add_pkt_byte(8'h00);
        add_pkt_byte(uvcfa_pkg::JPEG_FF);
        add_pkt_byte(uvcfa_pkg::JPEG_EOI);
        ship_packet(23'(pkt_q.size()), pkt_q.size());
        send_byte(8'h5a, 1'b0, '0);

        while (sent_items < RANDOM_ITEMS)
        begin
            case (sent_items * 4 / RANDOM_ITEMS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 76;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 76;
                end
                default:
                begin
                    idle_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            send_frame();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (ops_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: uvc_mjpeg_frame_assembler_core.f
src/uvcfa_pkg.sv
src/uvcfa_front.sv
src/uvcfa_fifo.sv
src/uvcfa_back.sv
src/uvc_mjpeg_frame_assembler_core.sv
tb/tb_uvc_mjpeg_frame_assembler_checker.sv
tb/tb_uvc_mjpeg_frame_assembler_core.sv
